/* hw/rtl/okvt_pkg.sv */
// ----------------------------------------------------------------------------
// okvt_pkg
// Shared types, codes and name checks for the ordered key/value table.
// ----------------------------------------------------------------------------
package okvt_pkg;

  typedef enum logic [1:0] {
    CMD_GET   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_LIST  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_MORE   = 3'd3,
    ST_RESERVED  = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FIN
  } fsm_t;

  localparam logic [7:0] CHAR_LOW  = 8'h20;
  localparam logic [7:0] CHAR_HIGH = 8'h7f;
  localparam logic [7:0] CHAR_RSVD = 8'h5f;  // '_'

  function automatic logic name_ok(input logic [31:0] k);
    logic ok;
    logic [7:0] c;
    ok = 1'b1;
    for (int s = 0; s < 4; s++) begin
      c = k[8*s +: 8];
      if (c <= CHAR_LOW || c >= CHAR_HIGH) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic name_reserved(input logic [31:0] k);
    return k[31:24] == CHAR_RSVD;
  endfunction

endpackage

/* hw/rtl/okvt_ram.sv */
// ----------------------------------------------------------------------------
// okvt_ram
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module okvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ordered_key_value_table.sv */
// ----------------------------------------------------------------------------
// ordered_key_value_table
// Bounded table of 32-bit values keyed by four-character names.
// ----------------------------------------------------------------------------
// Each transaction sweeps the key and value memories entry by entry through
// their single read port, waits for the last read to return, then decides
// and writes back. Keys and values live in two synchronous memories;
// occupancy bits and the changed flag are flip-flops cleared by reset. The
// result is held in an output register, so the next command is accepted
// while an earlier result still waits. Commands are accepted only in the
// idle state, so a new command waits until the previous one has finished
// its scan and decision; a result stalled at the output holds the
// following command in its decide state until the output register frees up.
module ordered_key_value_table #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] key,
  input  logic [31:0] data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] key_out,
  output logic [31:0] data_out,
  output logic        changed_flag
);
  import okvt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ENTRIES);

  fsm_t state, state_next;

  cmd_t        cmd_r;
  logic [31:0] key_r;
  logic [31:0] din_r;
  logic [CNT_W-1:0] cnt;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [ENTRIES-1:0] used;
  logic               dirty;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [31:0]      hit_data;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             best_found;
  logic [31:0]      best_key;
  logic [31:0]      best_data;

  logic [31:0] rd_key;
  logic [31:0] rd_data;
  logic        rd_used;

  logic        accept;
  logic        fin_go;
  status_t     res_status;
  logic [31:0] res_key;
  logic [31:0] res_data;
  logic        dirty_next;
  logic        wr_data_en;
  logic        wr_key_en;
  logic [IDX_W-1:0] wr_idx;

  okvt_ram #(.WIDTH(32), .DEPTH(ENTRIES), .AW(IDX_W)) u_key_ram (
    .clk   (clk),
    .we    (fin_go && wr_key_en),
    .waddr (wr_idx),
    .wdata (key_r),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rd_key)
  );

  okvt_ram #(.WIDTH(32), .DEPTH(ENTRIES), .AW(IDX_W)) u_data_ram (
    .clk   (clk),
    .we    (fin_go && wr_data_en),
    .waddr (wr_idx),
    .wdata (din_r),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign rd_used = used[rd_idx];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: if (in_valid) state_next = FSM_SCAN;
      FSM_SCAN: if (cnt == LAST) state_next = FSM_FIN;
      FSM_FIN:  if (!out_valid || !out_stall) state_next = FSM_IDLE;
      default:  state_next = FSM_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    fin_go   = 1'b0;
    unique case (state)
      FSM_IDLE: in_stall = 1'b0;
      FSM_SCAN: in_stall = 1'b1;
      FSM_FIN:  fin_go   = !out_valid || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // decide the result and the write-back from the scan summary
  always_comb begin
    res_status = ST_OK;
    res_key    = key_r;
    res_data   = '0;
    dirty_next = dirty;
    wr_data_en = 1'b0;
    wr_key_en  = 1'b0;
    wr_idx     = hit_idx;
    unique case (cmd_r) inside
      CMD_GET, CMD_SET: begin
        if (name_reserved(key_r)) begin
          res_status = ST_RESERVED;
        end else if (!name_ok(key_r)) begin
          res_status = ST_INVALID;
        end else if (cmd_r == CMD_GET) begin
          if (hit) res_data = hit_data;
          else     res_status = ST_NOT_FOUND;
        end else if (hit) begin
          wr_data_en = 1'b1;
          if (hit_data != din_r) dirty_next = 1'b1;
        end else if (free_found) begin
          wr_idx     = free_idx;
          wr_data_en = 1'b1;
          wr_key_en  = 1'b1;
          dirty_next = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_LIST: begin
        if (best_found) begin
          res_key  = best_key;
          res_data = best_data;
        end else begin
          res_status = ST_NO_MORE;
        end
      end
      CMD_CLEAR: dirty_next = 1'b0;
      default:   dirty_next = dirty;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FSM_IDLE;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      used       <= '0;
      dirty      <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == FSM_SCAN) && (cnt != LAST);
      if (accept) begin
        cnt        <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        best_found <= 1'b0;
      end else if (state == FSM_SCAN && cnt != LAST) begin
        cnt <= cnt + 1'b1;
      end
      // fold in one entry per cycle as reads return
      if (rd_vld) begin
        if (rd_used) begin
          if (rd_key == key_r) hit <= 1'b1;
          if (rd_key > key_r && (!best_found || rd_key < best_key)) best_found <= 1'b1;
        end else begin
          free_found <= 1'b1;
        end
      end
      if (fin_go) begin
        dirty <= dirty_next;
        if (wr_key_en) used[wr_idx] <= 1'b1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(cmd);
      key_r <= key;
      din_r <= data_in;
    end
    rd_idx <= cnt[IDX_W-1:0];
    if (rd_vld) begin
      if (rd_used) begin
        if (rd_key == key_r) begin
          hit_idx  <= rd_idx;
          hit_data <= rd_data;
        end
        if (rd_key > key_r && (!best_found || rd_key < best_key)) begin
          best_key  <= rd_key;
          best_data <= rd_data;
        end
      end else if (!free_found) begin
        free_idx <= rd_idx;
      end
    end
    if (fin_go) begin
      status       <= res_status;
      key_out      <= res_key;
      data_out     <= res_data;
      changed_flag <= dirty_next;
    end
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for ordered_key_value_table
// Drives get, set, list_next and clear_changed commands through the valid/stall
// handshake and predicts each reply with a shadow copy of the table and the
// changed flag. A directed pass covers reserved and invalid names, value
// updates and ordered listing, then random traffic with bursty input and
// receiver back-pressure fills the table and walks it.
// ----------------------------------------------------------------------------
module testbench;
  import okvt_pkg::*;

  localparam int TABLE_SIZE   = 16;
  localparam int POOL_SIZE    = 24;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_LIMIT  = 5000;

  typedef struct {
    status_t     status;
    logic [31:0] key;
    logic [31:0] data;
    logic        changed;
  } reply_t;

  class table_scoreboard;
    logic [31:0] slot_key [TABLE_SIZE];
    logic [31:0] slot_data [TABLE_SIZE];
    bit          slot_used [TABLE_SIZE];
    bit          dirty = 1'b0;
    reply_t      pending_replies [$];
    int          errors = 0;

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    function bit printable(logic [31:0] k);
      logic [7:0] c;
      for (int b = 0; b < 4; b++) begin
        c = k[8*b +: 8];
        if (c <= CHAR_LOW || c >= CHAR_HIGH) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int find_slot(logic [31:0] k);
      foreach (slot_used[i])
        if (slot_used[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    // smallest stored key strictly above k
    function int successor(logic [31:0] k);
      int best;
      best = -1;
      foreach (slot_used[i])
        if (slot_used[i] && slot_key[i] > k && (best < 0 || slot_key[i] < slot_key[best]))
          best = i;
      return best;
    endfunction

    function void note_command(logic [1:0] c, logic [31:0] k, logic [31:0] d);
      reply_t r;
      int s;
      r.status = ST_OK;
      r.key = k;
      r.data = '0;
      case (c) inside
        CMD_GET, CMD_SET: begin
          if (k[31:24] == CHAR_RSVD) begin
            r.status = ST_RESERVED;
          end else if (!printable(k)) begin
            r.status = ST_INVALID;
          end else begin
            s = find_slot(k);
            if (c == CMD_GET) begin
              if (s >= 0) r.data = slot_data[s];
              else r.status = ST_NOT_FOUND;
            end else if (s >= 0) begin
              if (slot_data[s] != d) dirty = 1'b1;
              slot_data[s] = d;
            end else begin
              // insert into the lowest free slot
              foreach (slot_used[i])
                if (!slot_used[i] && s < 0) s = i;
              if (s < 0) begin
                r.status = ST_FULL;
              end else begin
                slot_used[s] = 1'b1;
                slot_key[s] = k;
                slot_data[s] = d;
                dirty = 1'b1;
              end
            end
          end
        end
        CMD_LIST: begin
          s = successor(k);
          if (s >= 0) begin
            r.key = slot_key[s];
            r.data = slot_data[s];
          end else begin
            r.status = ST_NO_MORE;
          end
        end
        default: dirty = 1'b0;
      endcase
      r.changed = dirty;
      pending_replies.push_back(r);
    endfunction

    task check_result(logic [2:0] st, logic [31:0] ko, logic [31:0] dout, logic ch);
      reply_t r;
      if (pending_replies.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d key %h", st, ko));
        return;
      end
      r = pending_replies.pop_front();
      if (st !== r.status)
        report($sformatf("status %0d, expected %0d (key %h)", st, r.status, r.key));
      if (ko !== r.key)
        report($sformatf("key_out %h, expected %h", ko, r.key));
      if (dout !== r.data)
        report($sformatf("data_out %h, expected %h (key %h)", dout, r.data, r.key));
      if (ch !== r.changed)
        report($sformatf("changed_flag %b, expected %b (key %h)", ch, r.changed, r.key));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_GET;
  logic [31:0] key = '0;
  logic [31:0] data_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] key_out;
  logic [31:0] data_out;
  logic        changed_flag;

  table_scoreboard sb = new();
  logic [31:0] name_pool [POOL_SIZE];
  int items_sent = 0;
  int burst_left = 0;
  bit held_off = 1'b0;

  ordered_key_value_table #(.ENTRIES(TABLE_SIZE)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .key(key), .data_in(data_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .key_out(key_out), .data_out(data_out),
    .changed_flag(changed_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  function logic [31:0] printable_name();
    logic [31:0] k;
    for (int b = 0; b < 4; b++) k[8*b +: 8] = 8'($urandom_range(8'h21, 8'h7e));
    if (k[31:24] == CHAR_RSVD) k[31:24] = 8'h41;
    return k;
  endfunction

  function logic [31:0] pick_key();
    logic [31:0] k;
    int roll;
    int b;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      k = name_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (roll < 80) begin
      k = printable_name();
    end else if (roll < 88) begin
      k = {CHAR_RSVD, 24'($urandom)};
    end else if (roll < 95) begin
      // corrupt one byte with a non-printable value, edges favored
      k = printable_name();
      b = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0: k[8*b +: 8] = CHAR_LOW;
        1: k[8*b +: 8] = CHAR_HIGH;
        2: k[8*b +: 8] = 8'($urandom_range(0, 8'h20));
        default: k[8*b +: 8] = 8'($urandom_range(8'h7f, 8'hff));
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  // Hold valid across bursts; drop it for a random gap between them.
  task send_command(logic [1:0] c, logic [31:0] k, logic [31:0] d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 4) != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid = 1'b1;
    cmd = c;
    key = k;
    data_in = d;
    do @(posedge clk); while (in_stall);
    sb.note_command(c, k, d);
    items_sent++;
  endtask

  task walk_table();
    logic [31:0] k;
    int s;
    k = '0;
    do begin
      send_command(CMD_LIST, k, $urandom);
      s = sb.successor(k);
      if (s >= 0) k = sb.slot_key[s];
    end while (s >= 0);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, key_out, data_out, changed_flag);
  end

  // Receiver back-pressure: segments of free flow, light, heavy and periodic
  // stalls, plus one long hold-off while the sender keeps offering.
  initial begin
    int mode;
    int len;
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_off && items_sent >= 150) begin
        held_off = 1'b1;
        for (n = 0; n < 300; n++) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 200);
      for (n = 0; n < len; n++) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = (n % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    int start;
    int roll;
    int s;
    int drain;
    logic [31:0] k;
    logic [31:0] d;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (name_pool[i]) name_pool[i] = printable_name();

    send_command(CMD_LIST, 32'h0000_0000, 32'hffff_ffff);  // empty table
    send_command(CMD_GET, 32'h4142_4344, 32'h0);
    send_command(CMD_GET, 32'h5f41_4243, 32'h0);
    send_command(CMD_SET, 32'h5f41_4243, 32'h1);
    send_command(CMD_SET, 32'h5f00_0000, 32'h2);  // reserved wins over invalid
    send_command(CMD_GET, 32'h2041_4243, 32'h0);
    send_command(CMD_SET, 32'h4142_437f, 32'h3);
    send_command(CMD_GET, 32'h41ff_4243, 32'h0);
    send_command(CMD_SET, 32'h2121_2121, 32'h0000_0000);
    send_command(CMD_SET, 32'h7e7e_7e7e, 32'hffff_ffff);
    send_command(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    send_command(CMD_SET, 32'h2121_2121, 32'h0000_0000);  // same value, flag stays low
    send_command(CMD_SET, 32'h2121_2121, 32'h1234_5678);
    send_command(CMD_GET, 32'h2121_2121, 32'h0);
    send_command(CMD_GET, 32'h415f_4243, 32'h0);  // underscore below the top byte
    send_command(CMD_LIST, 32'h0000_0000, 32'h0);
    send_command(CMD_LIST, 32'h2121_2121, 32'h0);
    send_command(CMD_LIST, 32'h7e7e_7e7e, 32'h0);
    send_command(CMD_LIST, 32'hffff_ffff, 32'h0);
    send_command(CMD_LIST, 32'h5000_0000, 32'h0);
    send_command(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      k = pick_key();
      if (roll < 30) begin
        send_command(CMD_GET, k, $urandom);
      end else if (roll < 60) begin
        d = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          s = sb.find_slot(k);
          if (s >= 0) d = sb.slot_data[s];
        end else if ($urandom_range(0, 5) == 0) begin
          d = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
        end
        send_command(CMD_SET, k, d);
      end else if (roll < 78) begin
        case ($urandom_range(0, 3))
          0: k = 32'h0000_0000;
          1: k = 32'hffff_ffff;
          2: k = $urandom;
          default: ;
        endcase
        send_command(CMD_LIST, k, $urandom);
      end else if (roll < 90) begin
        walk_table();
      end else begin
        send_command(CMD_CLEAR, $urandom, $urandom);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    drain = 0;
    while (sb.pending_replies.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (2 * (TABLE_SIZE + 2)) @(posedge clk);
    if (sb.pending_replies.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_replies.size()));

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
